/* rtl/core/rrlp_pkg.sv */
// Shared types, character codes and helper functions of the receive line parser.
package rrlp_pkg;

    // Character codes seen on the modem serial line.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Number and length limits.
    localparam logic [16:0] ACC_MAX         = 17'h1FFFF;
    localparam logic [9:0]  OUT_SAT         = 10'd999;
    localparam logic [16:0] MAX_PAYLOAD_LEN = 17'd240;
    localparam logic [2:0]  TAG_LEN         = 3'd5;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_LSTART,
        PH_PREFIX,
        PH_IGNORE,
        PH_ADDR,
        PH_LEN,
        PH_PAYLOAD,
        PH_SEEK,
        PH_RSSI,
        PH_SNR,
        PH_BAD
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] digit;
        logic       is_lf;
        logic       is_blank;
        logic       is_digit;
        logic       is_comma;
        logic       is_sign;
        logic       is_minus;
        logic       is_point;
    } t_beat;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] addr;
        logic [7:0]  len;
        logic [10:0] rssi;
        logic [10:0] snr;
    } t_result;

    // Character of the line tag at a given position.
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_PLUS;
            3'd1:    c = CH_R;
            3'd2:    c = CH_C;
            3'd3:    c = CH_V;
            3'd4:    c = CH_EQ;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Clamp a magnitude to the output range and apply the sign.
    function automatic logic [10:0] clamp11(input logic [16:0] mag, input logic neg);
        logic [10:0] m;
        m = (mag > {7'd0, OUT_SAT}) ? {1'b0, OUT_SAT} : {1'b0, mag[9:0]};
        return neg ? (11'd0 - m) : m;
    endfunction

endpackage

/* rtl/core/radio_receive_line_parser.sv */
// Top level of the radio receive line parser.
//
// Input channel: one received modem character a beat on i_rx_byte, taken at a
// rising edge where i_push is high and o_full is low. Carriage returns are
// taken and discarded. Result channel: while o_empty is low the oldest result
// is on o_kind, o_data_byte, o_src_address, o_payload_length, o_rssi and
// o_snr_tenths; it is taken at an edge where i_pop is high.
// Throughput is one character every cycle while o_full is low. A character
// goes through a four-entry beat queue to the parser, which handles one beat
// per cycle while the result queue has room; the result that a character
// causes is registered in the result queue, whose head is on the result ports.
// The parser writes into a two-entry result queue; when that holds two
// results the parser pauses, the beat queue fills and o_full rises once four
// beats wait in it. Raising i_pop again resumes flow with nothing lost.
// A synchronous active-low reset empties both queues and returns the parser
// to line start with all parsed values cleared.
module radio_receive_line_parser
    import rrlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_rx_byte,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic [15:0]        o_src_address,
    output logic [7:0]         o_payload_length,
    output logic signed [10:0] o_rssi,
    output logic signed [10:0] o_snr_tenths
);

    logic    wr;
    t_beat   beat;
    t_beat   head;
    logic    q_empty;
    logic    q_rd;
    t_result result;

    // Character classification.
    rrlp_front u_front (
        .i_push    (i_push),
        .i_full    (o_full),
        .i_rx_byte (i_rx_byte),
        .o_wr      (wr),
        .o_beat    (beat)
    );

    // Decoupling queue.
    rrlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_beat  (beat),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (o_full)
    );

    // Line parser and result queue.
    rrlp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (result)
    );

    // Result fields onto their ports.
    assign o_kind           = result.kind;
    assign o_data_byte      = result.data;
    assign o_src_address    = result.addr;
    assign o_payload_length = result.len;
    assign o_rssi           = $signed(result.rssi);
    assign o_snr_tenths     = $signed(result.snr);

endmodule

/* rtl/core/rrlp_front.sv */
// Front end: accepts received characters, drops carriage returns and classifies the rest.
module rrlp_front
    import rrlp_pkg::*;
(
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_rx_byte,
    output logic       o_wr,
    output t_beat      o_beat
);

    // A carriage return is accepted but never reaches the queue.
    assign o_wr = i_push && !i_full && (i_rx_byte != CH_CR);

    // Character classes used by the parser.
    always_comb begin
        o_beat          = '0;
        o_beat.ch       = i_rx_byte;
        o_beat.digit    = 4'(i_rx_byte - CH_ZERO);
        o_beat.is_lf    = (i_rx_byte == CH_LF);
        o_beat.is_blank = (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB) ||
                          (i_rx_byte == CH_VT) || (i_rx_byte == CH_FF);
        o_beat.is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        o_beat.is_comma = (i_rx_byte == CH_COMMA);
        o_beat.is_sign  = (i_rx_byte == CH_PLUS) || (i_rx_byte == CH_MINUS);
        o_beat.is_minus = (i_rx_byte == CH_MINUS);
        o_beat.is_point = (i_rx_byte == CH_POINT);
    end

endmodule

/* rtl/core/rrlp_queue.sv */
// Short queue of classified beats between the front and the back.
module rrlp_queue
    import rrlp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_beat i_beat,
    input  logic  i_rd,
    output t_beat o_head,
    output logic  o_empty,
    output logic  o_full
);

    t_beat             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update.
    always_comb begin
        n_wp  = i_wr ? r_wp + 1'b1 : r_wp;
        n_rp  = i_rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QCNT_W'(i_wr) - QCNT_W'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full) else $error("beat written into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty) else $error("beat read from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");

endmodule

/* rtl/core/rrlp_back.sv */
// Back end: line parser state machine and the two-entry result queue.
module rrlp_back
    import rrlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_beat   i_head,
    input  logic    i_q_empty,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [2:0]  r_prefix, n_prefix;
    logic [16:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_stop, n_stop;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [10:0] r_rssi, n_rssi;
    logic [1:0]  r_fp, n_fp;

    // Result queue.
    t_result     r_oq [2];
    logic        r_owp, r_orp;
    logic [1:0]  r_ocnt, n_ocnt;
    logic        out_room;
    logic        out_pop;

    // Result produced by the beat in hand.
    t_result     res;
    logic        res_push;

    // Number feed results.
    logic        frac;
    logic        frac_add;
    logic [20:0] acc_x10;
    logic [20:0] acc_sum;
    logic [16:0] acc_sat;
    logic [16:0] f_acc;
    logic        f_neg;
    logic        f_stop;
    logic [2:0]  f_prefix;
    logic [1:0]  f_fp;
    logic [16:0] snr_mag;
    logic [16:0] neg_acc;

    assign out_room = (r_ocnt != 2'd2);
    assign out_pop  = i_pop && (r_ocnt != 2'd0);
    assign o_q_rd   = !i_q_empty && out_room;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];

    // Shared multiply-by-ten and digit add with saturation; the first fraction digit is added without the multiply.
    always_comb begin
        frac     = (r_phase == PH_SNR);
        frac_add = frac && (r_fp == 2'd1) && i_head.is_digit;
        acc_x10  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
        acc_sum  = (frac_add ? {4'd0, r_acc} : acc_x10) +
                   {17'd0, (i_head.is_digit ? i_head.digit : 4'd0)};
        acc_sat  = (acc_sum > {4'd0, ACC_MAX}) ? ACC_MAX : acc_sum[16:0];
        snr_mag  = (r_fp == 2'd0) ? acc_sat : r_acc;
        neg_acc  = 17'd0 - r_acc;
    end

    // One character into the number being read.
    always_comb begin
        f_acc    = r_acc;
        f_neg    = r_neg;
        f_stop   = r_stop;
        f_prefix = r_prefix;
        f_fp     = r_fp;
        if (!r_stop) begin
            priority if (!r_prefix[0] && i_head.is_blank) begin
                f_prefix = r_prefix;
            end else if (!r_prefix[0] && i_head.is_sign) begin
                f_neg    = i_head.is_minus;
                f_prefix = 3'd1;
            end else begin
                f_prefix = 3'd1;
                priority if (i_head.is_digit) begin
                    if (frac && r_fp == 2'd1) begin
                        f_acc = acc_sat;
                        f_fp  = 2'd2;
                    end else if (!(frac && r_fp == 2'd2)) begin
                        f_acc = acc_sat;
                    end
                end else if (frac && i_head.is_point && r_fp == 2'd0) begin
                    f_acc = acc_sat;
                    f_fp  = 2'd1;
                end else begin
                    f_stop = 1'b1;
                end
            end
        end
    end

    // Parser next state and result.
    always_comb begin
        n_phase  = r_phase;
        n_prefix = r_prefix;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_stop   = r_stop;
        n_addr   = r_addr;
        n_len    = r_len;
        n_left   = r_left;
        n_rssi   = r_rssi;
        n_fp     = r_fp;
        res      = '0;
        res_push = 1'b0;
        if (o_q_rd) begin
            if (i_head.is_lf) begin
                // A newline ends every line; packet lines report ok or malformed.
                if (r_phase == PH_SNR) begin
                    res.kind = KIND_OK;
                    res.addr = r_addr;
                    res.len  = r_len;
                    res.rssi = r_rssi;
                    res.snr  = clamp11(snr_mag, r_neg);
                    res_push = 1'b1;
                end else if (r_phase >= PH_ADDR) begin
                    res.kind = KIND_BAD;
                    res_push = 1'b1;
                end
                n_phase  = PH_LSTART;
                n_prefix = 3'd0;
                n_acc    = '0;
                n_neg    = 1'b0;
                n_stop   = 1'b0;
                n_fp     = 2'd0;
                n_left   = 8'd0;
            end else begin
                unique case (r_phase)
                    PH_LSTART: begin
                        if (!i_head.is_blank) begin
                            if (i_head.ch == tag_char(3'd0)) begin
                                n_prefix = 3'd1;
                                n_phase  = PH_PREFIX;
                            end else begin
                                n_phase = PH_IGNORE;
                            end
                        end
                    end
                    PH_PREFIX: begin
                        if (r_prefix < TAG_LEN && i_head.ch == tag_char(r_prefix)) begin
                            n_prefix = r_prefix + 3'd1;
                            if (r_prefix + 3'd1 == TAG_LEN) begin
                                n_prefix = 3'd0;
                                n_acc    = '0;
                                n_neg    = 1'b0;
                                n_stop   = 1'b0;
                                n_fp     = 2'd0;
                                n_phase  = PH_ADDR;
                            end
                        end else begin
                            n_phase = PH_IGNORE;
                        end
                    end
                    PH_ADDR, PH_LEN, PH_RSSI: begin
                        if (i_head.is_comma) begin
                            n_prefix = 3'd0;
                            n_acc    = '0;
                            n_neg    = 1'b0;
                            n_stop   = 1'b0;
                            n_fp     = 2'd0;
                            if (r_phase == PH_ADDR) begin
                                n_addr  = r_neg ? neg_acc[15:0] : r_acc[15:0];
                                n_phase = PH_LEN;
                            end else if (r_phase == PH_LEN) begin
                                if ((r_neg && r_acc != '0) || r_acc > MAX_PAYLOAD_LEN) begin
                                    n_phase = PH_BAD;
                                end else begin
                                    n_len   = r_acc[7:0];
                                    n_left  = r_acc[7:0];
                                    n_phase = (r_acc[7:0] != 8'd0) ? PH_PAYLOAD : PH_SEEK;
                                end
                            end else begin
                                n_rssi  = clamp11(r_acc, r_neg);
                                n_phase = PH_SNR;
                            end
                        end else begin
                            n_prefix = f_prefix;
                            n_acc    = f_acc;
                            n_neg    = f_neg;
                            n_stop   = f_stop;
                            n_fp     = f_fp;
                        end
                    end
                    PH_PAYLOAD: begin
                        res.kind = KIND_DATA;
                        res.data = i_head.ch;
                        res.addr = r_addr;
                        res.len  = r_len;
                        res_push = 1'b1;
                        n_left   = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_SEEK;
                        end
                    end
                    PH_SEEK: begin
                        if (i_head.is_comma) begin
                            n_prefix = 3'd0;
                            n_acc    = '0;
                            n_neg    = 1'b0;
                            n_stop   = 1'b0;
                            n_fp     = 2'd0;
                            n_phase  = PH_RSSI;
                        end
                    end
                    PH_SNR: begin
                        n_prefix = f_prefix;
                        n_acc    = f_acc;
                        n_neg    = f_neg;
                        n_stop   = f_stop;
                        n_fp     = f_fp;
                    end
                    PH_IGNORE, PH_BAD: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        n_phase = PH_LSTART;
                    end
                endcase
            end
        end
    end

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LSTART;
            r_prefix <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_stop   <= 1'b0;
            r_addr   <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_rssi   <= '0;
            r_fp     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_prefix <= n_prefix;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_stop   <= n_stop;
            r_addr   <= n_addr;
            r_len    <= n_len;
            r_left   <= n_left;
            r_rssi   <= n_rssi;
            r_fp     <= n_fp;
        end
    end

    // Result queue pointers and count.
    assign n_ocnt = r_ocnt + 2'(res_push) - 2'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_owp  <= r_owp ^ res_push;
            r_orp  <= r_orp ^ out_pop;
            r_ocnt <= n_ocnt;
        end
    end

    // Result storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owp] <= res;
        end
    end

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != 8'd0)
        else $error("payload phase with no bytes left");
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> r_ocnt != 2'd2)
        else $error("result written into a full result queue");
    a_newline_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_rd && i_head.is_lf) |=> (r_phase == PH_LSTART && r_left == 8'd0))
        else $error("newline did not return the parser to line start");

endmodule
